// ===== hw/rtl/ppc_timebase_decrementer_exception_entry_assert.svh =====
// Assertion macros shared by the time base and exception entry RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef PPC_TIMEBASE_DECREMENTER_EXCEPTION_ENTRY_ASSERT_SVH
`define PPC_TIMEBASE_DECREMENTER_EXCEPTION_ENTRY_ASSERT_SVH

// Check a property while out of reset.
`define PTDE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define PTDE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ppctbdec_pkg.sv =====
// Types and constants for the time base, decrementer and exception entry block.
// Depends on nothing.
package ppctbdec_pkg;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [3:0] {
        CAUSE_DSI     = 4'd0,
        CAUSE_ISI     = 4'd1,
        CAUSE_EXT     = 4'd2,
        CAUSE_SYSCALL = 4'd3,
        CAUSE_NOFPU   = 4'd4,
        CAUSE_NOVEC   = 4'd5,
        CAUSE_PROGRAM = 4'd6,
        CAUSE_FASSIST = 4'd7,
        CAUSE_MCHECK  = 4'd8,
        CAUSE_TRACE   = 4'd9,
        CAUSE_DEC     = 4'd10
    } cause_t;

    localparam logic [31:0] SRR1_MASK   = 32'h87c0_ffff;
    localparam int          MSR_EE_POS  = 15;
    localparam logic [31:0] MSR_RI_BIT  = 32'h0000_0002;
    localparam logic [31:0] INSN_BYTES  = 32'd4;

    localparam logic [31:0] VEC_MCHECK  = 32'h0000_0200;
    localparam logic [31:0] VEC_DSI     = 32'h0000_0300;
    localparam logic [31:0] VEC_ISI     = 32'h0000_0400;
    localparam logic [31:0] VEC_EXT     = 32'h0000_0500;
    localparam logic [31:0] VEC_PROGRAM = 32'h0000_0700;
    localparam logic [31:0] VEC_NOFPU   = 32'h0000_0800;
    localparam logic [31:0] VEC_DEC     = 32'h0000_0900;
    localparam logic [31:0] VEC_SYSCALL = 32'h0000_0c00;
    localparam logic [31:0] VEC_TRACE   = 32'h0000_0d00;
    localparam logic [31:0] VEC_FASSIST = 32'h0000_0e00;
    localparam logic [31:0] VEC_NOVEC   = 32'h0000_0f20;

    typedef struct packed {
        logic        mode;
        logic [31:0] cycle_count;
        logic [3:0]  cause;
        logic [31:0] cause_flags;
        logic [31:0] fault_address;
        logic [31:0] current_pc;
        logic [31:0] current_msr;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        taken;
        logic [31:0] next_pc;
        logic [31:0] next_msr;
        logic [31:0] saved_pc;
        logic [31:0] saved_msr;
        logic [31:0] data_fault_address;
        logic [31:0] data_fault_status;
        logic        flush_tlb;
        logic [63:0] time_base;
        logic [31:0] decrementer_value;
    } rsp_t;

endpackage

// ===== hw/rtl/ppc_timebase_decrementer_exception_entry.sv =====
// Top level: time base, decrementer, pending interrupts and exception entry.
// Depends on ppctbdec_pkg and ppc_timebase_decrementer_exception_entry_assert.svh.
//
// Takes one request per clock while req_stall is low and returns one response per
// request once it has passed an input register, then a result register. The time
// base, decrementer, pending flags and SRR0/SRR1/DAR/DSISR update in the cycle
// a request moves from the input register to the result register, so the next
// request sees them at once; a 64-bit add plus a 32-bit compare and subtract set
// the cycle time. A waiting response blocks new requests only once the input
// register also holds one.
`include "ppc_timebase_decrementer_exception_entry_assert.svh"

module ppc_timebase_decrementer_exception_entry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ppctbdec_pkg::req_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ppctbdec_pkg::rsp_t  rsp
);
    import ppctbdec_pkg::*;

    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    logic [63:0] tb_reg;
    logic [31:0] dec_reg;
    logic        dec_pend_reg;
    logic        ext_pend_reg;
    logic [31:0] srr0_reg;
    logic [31:0] srr1_reg;
    logic [31:0] dar_reg;
    logic [31:0] dsisr_reg;

    logic [63:0] tb_next;
    logic [31:0] dec_next;
    logic        dec_pend_next;
    logic        ext_pend_next;
    logic [31:0] srr0_next;
    logic [31:0] srr1_next;
    logic [31:0] dar_next;
    logic [31:0] dsisr_next;
    rsp_t        rsp_next;

    logic        load_s1;
    logic        advance;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign load_s1   = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic        ee;
        logic        accepted;
        logic        taken;
        logic [31:0] vector;
        logic [31:0] masked;
        logic [31:0] back;
        ee       = s1_req_reg.current_msr[MSR_EE_POS];
        masked   = s1_req_reg.current_msr & SRR1_MASK;
        back     = s1_req_reg.current_pc - INSN_BYTES;
        accepted = 1'b1;
        taken    = 1'b0;
        vector   = '0;

        tb_next       = tb_reg;
        dec_next      = dec_reg;
        dec_pend_next = dec_pend_reg;
        ext_pend_next = ext_pend_reg;
        srr0_next     = srr0_reg;
        srr1_next     = srr1_reg;
        dar_next      = dar_reg;
        dsisr_next    = dsisr_reg;

        if (s1_req_reg.mode == MODE_TICK)
        begin
            tb_next = tb_reg + {32'd0, s1_req_reg.cycle_count};
            if (s1_req_reg.cycle_count >= dec_reg)
            begin
                if (ee)
                begin
                    dec_pend_next = 1'b1;
                    dec_next      = '0;
                end
            end
            else
            begin
                dec_next = dec_reg - s1_req_reg.cycle_count;
            end
            if (ee)
            begin
                if (dec_pend_next)
                begin
                    dec_pend_next = 1'b0;
                    vector        = VEC_DEC;
                    taken         = 1'b1;
                end
                else if (ext_pend_reg)
                begin
                    ext_pend_next = 1'b0;
                    vector        = VEC_EXT;
                    taken         = 1'b1;
                end
                if (taken)
                begin
                    srr0_next = s1_req_reg.current_pc;
                    srr1_next = masked;
                end
            end
        end
        else
        begin
            taken = 1'b1;
            case (s1_req_reg.cause)
                CAUSE_DSI:
                begin
                    srr0_next  = back;
                    srr1_next  = masked;
                    dar_next   = s1_req_reg.fault_address;
                    dsisr_next = s1_req_reg.cause_flags;
                    vector     = VEC_DSI;
                end
                CAUSE_ISI:
                begin
                    srr0_next = s1_req_reg.current_pc;
                    srr1_next = masked | s1_req_reg.cause_flags;
                    vector    = VEC_ISI;
                end
                CAUSE_EXT:
                begin
                    ext_pend_next = 1'b1;
                    taken         = 1'b0;
                end
                CAUSE_SYSCALL:
                begin
                    srr0_next = s1_req_reg.current_pc;
                    srr1_next = masked;
                    vector    = VEC_SYSCALL;
                end
                CAUSE_NOFPU:
                begin
                    srr0_next = back;
                    srr1_next = masked;
                    vector    = VEC_NOFPU;
                end
                CAUSE_NOVEC:
                begin
                    srr0_next = back;
                    srr1_next = masked;
                    vector    = VEC_NOVEC;
                end
                CAUSE_PROGRAM:
                begin
                    srr0_next = back;
                    srr1_next = masked | s1_req_reg.cause_flags;
                    vector    = VEC_PROGRAM;
                end
                CAUSE_FASSIST:
                begin
                    srr0_next = back;
                    srr1_next = masked;
                    vector    = VEC_FASSIST;
                end
                CAUSE_MCHECK:
                begin
                    srr0_next = back;
                    srr1_next = masked | MSR_RI_BIT;
                    vector    = VEC_MCHECK;
                end
                CAUSE_TRACE:
                begin
                    srr0_next = back;
                    srr1_next = masked;
                    vector    = VEC_TRACE;
                end
                CAUSE_DEC:
                begin
                    dec_pend_next = 1'b1;
                    taken         = 1'b0;
                end
                default:
                begin
                    accepted = 1'b0;
                    taken    = 1'b0;
                end
            endcase
        end

        rsp_next.accepted           = accepted;
        rsp_next.taken              = taken;
        rsp_next.next_pc            = taken ? vector : s1_req_reg.current_pc;
        rsp_next.next_msr           = taken ? 32'd0 : s1_req_reg.current_msr;
        rsp_next.saved_pc           = srr0_next;
        rsp_next.saved_msr          = srr1_next;
        rsp_next.data_fault_address = dar_next;
        rsp_next.data_fault_status  = dsisr_next;
        rsp_next.flush_tlb          = taken;
        rsp_next.time_base          = tb_next;
        rsp_next.decrementer_value  = dec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            tb_reg        <= '0;
            dec_reg       <= '0;
            dec_pend_reg  <= 1'b0;
            ext_pend_reg  <= 1'b0;
            srr0_reg      <= '0;
            srr1_reg      <= '0;
            dar_reg       <= '0;
            dsisr_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= load_s1 || (s1_valid_reg && !advance);
            rsp_valid_reg <= advance || (rsp_valid_reg && rsp_stall);
            if (advance)
            begin
                tb_reg       <= tb_next;
                dec_reg      <= dec_next;
                dec_pend_reg <= dec_pend_next;
                ext_pend_reg <= ext_pend_next;
                srr0_reg     <= srr0_next;
                srr1_reg     <= srr1_next;
                dar_reg      <= dar_next;
                dsisr_reg    <= dsisr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `PTDE_ASSERT(a_request_keeps_time_base, advance && s1_req_reg.mode == MODE_REQUEST |=> tb_reg == $past(tb_reg), "time base moved on an exception request")
    `PTDE_ASSERT(a_decrementer_never_rises, advance |=> dec_reg <= $past(dec_reg), "decrementer increased")
    `PTDE_ASSERT(a_taken_clears_msr, rsp_valid_reg && rsp_reg.taken |-> rsp_reg.accepted && rsp_reg.flush_tlb && rsp_reg.next_msr == 32'd0, "taken response without entry side effects")
    `PTDE_ASSERT_ALWAYS(a_stall_needs_full_stage, req_stall |-> s1_valid_reg && rsp_valid_reg, "request stalled with room in the pipeline")

endmodule
